FILE: hdl/fcl_pkg.sv
package fcl_pkg;

    localparam int CellCount   = 9;
    localparam int CentreSlot  = 4;
    localparam int FaceCount   = 6;
    localparam int CornerCount = 4;
    localparam int QueueDepth  = 2;

    localparam int FaceWidth   = 3;
    localparam int LightWidth  = 4;
    localparam int SumWidth    = 6;
    localparam int OcntWidth   = 3;
    localparam int SlotWidth   = 4;
    localparam int VertexWidth = 2;

    // Fixed slots of the neighbourhood, du outer, dv inner
    localparam logic [SlotWidth-1:0] SlotLoLo = 4'd0;
    localparam logic [SlotWidth-1:0] SlotLoHi = 4'd2;
    localparam logic [SlotWidth-1:0] SlotHiLo = 4'd6;
    localparam logic [SlotWidth-1:0] SlotHiHi = 4'd8;
    localparam logic [SlotWidth-1:0] SlotULo  = 4'd1;
    localparam logic [SlotWidth-1:0] SlotUHi  = 4'd7;
    localparam logic [SlotWidth-1:0] SlotVLo  = 4'd3;
    localparam logic [SlotWidth-1:0] SlotVHi  = 4'd5;
    localparam logic [SlotWidth-1:0] SlotLast = 4'd8;

    typedef enum logic [FaceWidth-1:0] {
        FACE_DOWN  = 3'd0,
        FACE_UP    = 3'd1,
        FACE_EAST  = 3'd2,
        FACE_WEST  = 3'd3,
        FACE_NORTH = 3'd4,
        FACE_SOUTH = 3'd5
    } t_face;

    typedef struct packed {
        logic                  transmits_light;
        logic                  opaque;
        logic [LightWidth-1:0] sky_light;
        logic [LightWidth-1:0] block_light;
    } t_cell;

    // One complete face neighbourhood, handed from front to back
    typedef struct packed {
        logic [FaceWidth-1:0]  face;
        t_cell [CellCount-1:0] cells;
    } t_face_job;

    // Corner of a face at a winding position, as {u_high, v_high}
    function automatic logic [1:0] winding(input logic [FaceWidth-1:0] face,
                                           input logic [VertexWidth-1:0] k);
        logic [7:0] row;
        row = 8'h00;
        case (face)
            FACE_DOWN:  row = 8'b11_10_00_01;
            FACE_UP:    row = 8'b01_00_10_11;
            FACE_EAST:  row = 8'b00_10_11_01;
            FACE_WEST:  row = 8'b11_10_00_01;
            FACE_NORTH: row = 8'b10_00_01_11;
            FACE_SOUTH: row = 8'b11_01_00_10;
            default:    row = 8'h00;
        endcase
        return row[{k, 1'b0} +: 2];
    endfunction

endpackage

FILE: hdl/fcl_if.sv
interface fcl_cell_if;
    logic                                valid;
    logic                                ready;
    logic [fcl_pkg::FaceWidth-1:0]       face;
    logic [fcl_pkg::LightWidth-1:0]      block_light;
    logic [fcl_pkg::LightWidth-1:0]      sky_light;
    logic                                opaque;
    logic                                transmits_light;
    logic                                last_cell;

    modport source (output valid, face, block_light, sky_light, opaque, transmits_light,
                    last_cell, input ready);
    modport sink (input valid, face, block_light, sky_light, opaque, transmits_light,
                  last_cell, output ready);
endinterface

interface fcl_corner_if;
    logic                                valid;
    logic                                ready;
    logic [fcl_pkg::VertexWidth-1:0]     vertex_index;
    logic [fcl_pkg::SumWidth-1:0]        block_light_sum;
    logic [fcl_pkg::SumWidth-1:0]        sky_light_sum;
    logic [fcl_pkg::OcntWidth-1:0]       opaque_count;
    logic [fcl_pkg::LightWidth-1:0]      centre_block_light;
    logic [fcl_pkg::LightWidth-1:0]      centre_sky_light;
    logic                                last_corner;

    modport source (output valid, vertex_index, block_light_sum, sky_light_sum, opaque_count,
                    centre_block_light, centre_sky_light, last_corner, input ready);
    modport sink (input valid, vertex_index, block_light_sum, sky_light_sum, opaque_count,
                  centre_block_light, centre_sky_light, last_corner, output ready);
endinterface

FILE: hdl/face_corner_light_occlusion_core.sv
// Channel   Dir  Word                                                  Accepted when
// i_cell    in   face, block/sky light, opaque, transmits, last_cell   valid && ready
// o_corner  out  vertex, light sums, opaque count, centre light, last  valid && ready
//
// Cells are taken one per cycle while the face queue has room; a face is nine cells.
// Corners come from the queue head, four per face, one per cycle unless stalled.
// The last cell's face is queued, then its first corner is registered at the output.
// Reset (synchronous, active low) clears the slot counter, queue pointers, corner index and output valid.
// i_cell stalls only while the face queue is full; o_corner stalls hold the output word.
module face_corner_light_occlusion_core #(
    parameter int QueueDepth = fcl_pkg::QueueDepth
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fcl_cell_if.sink      i_cell,
    fcl_corner_if.source  o_corner
);

    logic                q_push;
    logic                q_ready;
    logic                q_valid;
    logic                q_pop;
    fcl_pkg::t_face_job  q_in;
    fcl_pkg::t_face_job  q_out;

    fcl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cell      (i_cell),
        .i_job_ready (q_ready),
        .o_job_valid (q_push),
        .o_job       (q_in)
    );

    fcl_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_out),
        .i_pop   (q_pop)
    );

    fcl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_out),
        .o_pop       (q_pop),
        .o_corner    (o_corner)
    );

endmodule

FILE: hdl/fcl_front.sv
module fcl_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    fcl_cell_if.sink            i_cell,
    input  logic                i_job_ready,
    output logic                o_job_valid,
    output fcl_pkg::t_face_job  o_job
);

    logic [fcl_pkg::SlotWidth-1:0] r_count;
    logic [fcl_pkg::SlotWidth-1:0] n_count;
    fcl_pkg::t_cell                r_store [fcl_pkg::CellCount];
    fcl_pkg::t_cell                w_cell;
    logic                          w_accept;

    // Stall cells while the queue has no room for a finished face
    assign i_cell.ready = i_job_ready;
    assign w_accept     = i_cell.valid && i_job_ready;

    assign w_cell.transmits_light = i_cell.transmits_light;
    assign w_cell.opaque          = i_cell.opaque;
    assign w_cell.sky_light       = i_cell.sky_light;
    assign w_cell.block_light     = i_cell.block_light;

    // Advance slot, saturate on the ninth, restart after the last cell
    always_comb begin
        n_count = r_count;
        if (i_cell.last_cell) begin
            n_count = '0;
        end else if (r_count != fcl_pkg::SlotLast) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_store[r_count] <= w_cell;
        end
    end

    // Snapshot the neighbourhood with the incoming cell in its slot
    always_comb begin
        o_job.face = i_cell.face;
        for (int s = 0; s < fcl_pkg::CellCount; s++) begin
            if (r_count == fcl_pkg::SlotWidth'(s)) begin
                o_job.cells[s] = w_cell;
            end else begin
                o_job.cells[s] = r_store[s];
            end
        end
    end

    // Drop faces with a number outside the six
    assign o_job_valid = w_accept && i_cell.last_cell &&
                         (i_cell.face < fcl_pkg::FaceWidth'(fcl_pkg::FaceCount));

endmodule

FILE: hdl/fcl_queue.sv
module fcl_queue #(
    parameter int Depth = fcl_pkg::QueueDepth
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  fcl_pkg::t_face_job  i_data,
    output logic                o_ready,
    output logic                o_valid,
    output fcl_pkg::t_face_job  o_data,
    input  logic                i_pop
);

    localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntWidth = $clog2(Depth + 1);

    fcl_pkg::t_face_job     r_mem [Depth];
    logic [PtrWidth-1:0]    r_wr_ptr;
    logic [PtrWidth-1:0]    r_rd_ptr;
    logic [CntWidth-1:0]    r_fill;
    logic                   w_push;
    logic                   w_pop;

    assign o_ready = (r_fill != CntWidth'(Depth));
    assign o_valid = (r_fill != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Track pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrWidth'(Depth - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrWidth'(Depth - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (w_pop && !w_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/fcl_back.sv
module fcl_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  fcl_pkg::t_face_job  i_job,
    output logic                o_pop,
    fcl_corner_if.source        o_corner
);

    logic [fcl_pkg::VertexWidth-1:0] r_k;
    logic                            r_valid;
    logic [fcl_pkg::VertexWidth-1:0] r_vertex;
    logic [fcl_pkg::SumWidth-1:0]    r_bsum;
    logic [fcl_pkg::SumWidth-1:0]    r_ssum;
    logic [fcl_pkg::OcntWidth-1:0]   r_ocnt;
    logic [fcl_pkg::LightWidth-1:0]  r_cblk;
    logic [fcl_pkg::LightWidth-1:0]  r_csky;
    logic                            r_last;

    logic                            w_advance;
    logic [1:0]                      w_corner;
    fcl_pkg::t_cell                  w_ctr;
    fcl_pkg::t_cell                  w_side;
    fcl_pkg::t_cell                  w_other;
    fcl_pkg::t_cell                  w_diag;
    logic [fcl_pkg::LightWidth-1:0]  w_b_side, w_b_other, w_b_diag;
    logic [fcl_pkg::LightWidth-1:0]  w_s_side, w_s_other, w_s_diag;
    logic [fcl_pkg::SumWidth-1:0]    w_bsum;
    logic [fcl_pkg::SumWidth-1:0]    w_ssum;
    logic [fcl_pkg::OcntWidth-1:0]   w_ocnt;

    // Step one corner whenever a face is queued and the output register is free or being drained
    assign w_advance = i_job_valid && (!r_valid || o_corner.ready);
    assign o_pop     = w_advance && (r_k == fcl_pkg::VertexWidth'(fcl_pkg::CornerCount - 1));

    // Pick the four cells of this corner
    always_comb begin
        w_corner = fcl_pkg::winding(i_job.face, r_k);
        w_ctr    = i_job.cells[fcl_pkg::CentreSlot];
        w_side   = w_corner[1] ? i_job.cells[fcl_pkg::SlotUHi] : i_job.cells[fcl_pkg::SlotULo];
        w_other  = w_corner[0] ? i_job.cells[fcl_pkg::SlotVHi] : i_job.cells[fcl_pkg::SlotVLo];
        case (w_corner)
            2'b00:   w_diag = i_job.cells[fcl_pkg::SlotLoLo];
            2'b01:   w_diag = i_job.cells[fcl_pkg::SlotLoHi];
            2'b10:   w_diag = i_job.cells[fcl_pkg::SlotHiLo];
            2'b11:   w_diag = i_job.cells[fcl_pkg::SlotHiHi];
            default: w_diag = i_job.cells[fcl_pkg::SlotLoLo];
        endcase
        // Closed corner: side edge stands in for the diagonal
        if (!w_side.transmits_light && !w_other.transmits_light) begin
            w_diag = w_side;
        end
    end

    // Replace dark neighbours with the centre level
    always_comb begin
        w_b_side  = (w_side.block_light  == '0) ? w_ctr.block_light : w_side.block_light;
        w_b_other = (w_other.block_light == '0) ? w_ctr.block_light : w_other.block_light;
        w_b_diag  = (w_diag.block_light  == '0) ? w_ctr.block_light : w_diag.block_light;
        w_s_side  = (w_side.sky_light    == '0) ? w_ctr.sky_light   : w_side.sky_light;
        w_s_other = (w_other.sky_light   == '0) ? w_ctr.sky_light   : w_other.sky_light;
        w_s_diag  = (w_diag.sky_light    == '0) ? w_ctr.sky_light   : w_diag.sky_light;
        w_bsum = fcl_pkg::SumWidth'(w_b_side) + fcl_pkg::SumWidth'(w_b_other) +
                 fcl_pkg::SumWidth'(w_b_diag) + fcl_pkg::SumWidth'(w_ctr.block_light);
        w_ssum = fcl_pkg::SumWidth'(w_s_side) + fcl_pkg::SumWidth'(w_s_other) +
                 fcl_pkg::SumWidth'(w_s_diag) + fcl_pkg::SumWidth'(w_ctr.sky_light);
        w_ocnt = fcl_pkg::OcntWidth'(w_side.opaque) + fcl_pkg::OcntWidth'(w_other.opaque) +
                 fcl_pkg::OcntWidth'(w_diag.opaque) + fcl_pkg::OcntWidth'(w_ctr.opaque);
    end

    // Control: corner index and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_k     <= r_k + 1'b1;
                r_valid <= 1'b1;
            end else if (o_corner.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_vertex <= r_k;
            r_bsum   <= w_bsum;
            r_ssum   <= w_ssum;
            r_ocnt   <= w_ocnt;
            r_cblk   <= w_ctr.block_light;
            r_csky   <= w_ctr.sky_light;
            r_last   <= (r_k == fcl_pkg::VertexWidth'(fcl_pkg::CornerCount - 1));
        end
    end

    assign o_corner.valid              = r_valid;
    assign o_corner.vertex_index       = r_vertex;
    assign o_corner.block_light_sum    = r_bsum;
    assign o_corner.sky_light_sum      = r_ssum;
    assign o_corner.opaque_count       = r_ocnt;
    assign o_corner.centre_block_light = r_cblk;
    assign o_corner.centre_sky_light   = r_csky;
    assign o_corner.last_corner        = r_last;

endmodule

FILE: hdl/fcl_checker.sv
module fcl_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic [fcl_pkg::VertexWidth-1:0]    i_vertex_index,
    input logic [fcl_pkg::SumWidth-1:0]       i_block_light_sum,
    input logic [fcl_pkg::SumWidth-1:0]       i_sky_light_sum,
    input logic [fcl_pkg::OcntWidth-1:0]      i_opaque_count,
    input logic                               i_last_corner
);

    // Stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid &&
            $stable(i_vertex_index) && $stable(i_block_light_sum))
        else $error("corner word changed while stalled");

    // Last flag marks the fourth corner only
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_last_corner == (i_vertex_index == 2'd3)))
        else $error("last_corner disagrees with vertex_index");

    // Corners of a face follow back to back
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last_corner |=>
            i_out_valid && (i_vertex_index == $past(i_vertex_index) + 2'd1))
        else $error("corner sequence broken");

    // Sums and count stay in range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_block_light_sum <= 6'd60) && (i_sky_light_sum <= 6'd60) &&
            (i_opaque_count <= 3'd4))
        else $error("corner result out of range");

    // No word right after reset
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind face_corner_light_occlusion_core fcl_checker u_fcl_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_corner.valid),
    .i_out_ready       (o_corner.ready),
    .i_vertex_index    (o_corner.vertex_index),
    .i_block_light_sum (o_corner.block_light_sum),
    .i_sky_light_sum   (o_corner.sky_light_sum),
    .i_opaque_count    (o_corner.opaque_count),
    .i_last_corner     (o_corner.last_corner)
);
